// ===== sv/maximal_square_finder_assert.svh =====
// assertion macros shared by the maximal square finder rtl
`ifndef MAXIMAL_SQUARE_FINDER_ASSERT_SVH
`define MAXIMAL_SQUARE_FINDER_ASSERT_SVH

// checked on every clock edge outside reset
`define MSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define MSQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/msq_pkg.sv =====
// shared types, constants and helpers of the maximal square finder
`default_nettype none

package msq_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int SIDE_W   = 11;
    localparam int AREA_W   = 21;
    localparam int WIDTH_W  = 11;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    typedef logic [SIDE_W-1:0]  t_side;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [AREA_W-1:0]  t_area;
    typedef logic [WIDTH_W-1:0] t_width;

    localparam t_width WIDTH_RESET = WIDTH_W'(MAX_COLS);

    // register index is the word address
    typedef enum logic [ADDR_W-3:0] {
        REG_ROW_WIDTH = '0
    } t_reg_idx;

    // broadcast from the scan logic to every cell of the line chain
    typedef struct packed {
        logic  wr_en;   // one cell transfer per accepted item
        logic  load;    // next column is zero: reload window from the row store
        t_col  col;     // column being written
        t_side side;    // side written at that column
    } t_line_ctrl;

    // last column index for a configured width, width clamped to 1..MAX_COLS
    function automatic t_col last_col_of(input t_width w);
        t_col r;
        if (w == '0) begin
            r = '0;
        end else if (32'(w) > MAX_COLS) begin
            r = COL_W'(MAX_COLS - 1);
        end else begin
            r = COL_W'(w - t_width'(1));
        end
        return r;
    endfunction

    function automatic t_side min3(input t_side a, input t_side b, input t_side c);
        t_side m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/msq_cell.sv =====
// one line chain cell: row store entry plus one slot of the look-ahead window
`default_nettype none

module msq_cell (
    input  logic               i_clk,
    input  msq_pkg::t_col      i_index,
    input  msq_pkg::t_line_ctrl i_ctrl,
    input  msq_pkg::t_side     i_next,
    output msq_pkg::t_side     o_win
);
    import msq_pkg::*;

    logic  hit;
    t_side r_stored;
    t_side r_win;
    t_side n_win;

    assign hit = (i_ctrl.col == i_index);

    // window slot holds the side of column (current column + own index)
    always_comb begin
        if (i_ctrl.load) begin
            n_win = hit ? i_ctrl.side : r_stored;
        end else begin
            n_win = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            if (hit) begin
                r_stored <= i_ctrl.side;
            end
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule

`default_nettype wire

// ===== sv/msq_line_chain.sv =====
// row of cells holding the previous row's sides, head gives the upper side
`default_nettype none

module msq_line_chain (
    input  logic                i_clk,
    input  msq_pkg::t_line_ctrl i_ctrl,
    output msq_pkg::t_side      o_up
);
    import msq_pkg::*;

    t_side w_win [MAX_COLS+1];

    assign w_win[MAX_COLS] = '0;

    for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
        msq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (COL_W'(i)),
            .i_ctrl  (i_ctrl),
            .i_next  (w_win[i+1]),
            .o_win   (w_win[i])
        );
    end

    assign o_up = w_win[0];

endmodule

`default_nettype wire

// ===== sv/maximal_square_finder.sv =====
// top level of the streaming maximal all-ones square finder
// Takes one matrix cell per transfer in raster order and returns, for every
// cell, the side of the largest all-ones square ending there and the area of
// the largest square seen so far in the current matrix. One cell is accepted
// every clock cycle while the output is not stalled; each result is registered
// in stage one after the side recurrence and in the output register after the
// area multiply. The left-side recurrence (three-way minimum plus one) is
// combinational, and the row above is supplied by a chain of cells that shifts
// one place per transfer and reloads from its row store at each row start,
// so no clearing pass is needed after reset. row_width lives at byte address
// 0 of the register port; 0 acts as 1 and values above 1024 act as 1024. A
// cell with last_cell set ends the matrix and clears the scan state.
`default_nettype none

`include "maximal_square_finder_assert.svh"

module maximal_square_finder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // cell input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cell_bit,
    input  logic                         i_last_cell,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output msq_pkg::t_side               o_side_here,
    output msq_pkg::t_area               o_best_area,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msq_pkg::ADDR_W-1:0]   paddr,
    input  logic [msq_pkg::DATA_W-1:0]   pwdata,
    output logic [msq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import msq_pkg::*;

    // configuration
    t_width r_row_width;
    t_col   r_last_col;
    logic   cfg_wr;
    logic   sel_row_width;

    // scan state
    t_col   r_col,   n_col;
    t_side  r_left,  n_left;
    t_side  r_diag,  n_diag;
    logic   r_first, n_first;
    t_side  r_best,  n_best;

    // pipeline
    logic   r_s1_valid;
    t_side  r_s1_side;
    t_side  r_s1_best;
    logic   r_out_valid;
    t_side  r_out_side;
    t_area  r_out_area;
    logic   out_en;
    logic   s1_en;
    logic   in_acc;

    // datapath
    t_side      up;
    t_side      side;
    logic       row_end;
    t_line_ctrl line_ctrl;
    logic [2*SIDE_W-1:0] prod;

    // ---------------------------------------------------------------- registers
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign sel_row_width = (paddr[ADDR_W-1:2] == REG_ROW_WIDTH);
    assign prdata        = sel_row_width ? DATA_W'(r_row_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
            r_last_col  <= last_col_of(WIDTH_RESET);
        end else if (cfg_wr && sel_row_width) begin
            r_row_width <= pwdata[WIDTH_W-1:0];
            // clamped last column kept ready for the row-end compare
            r_last_col  <= last_col_of(pwdata[WIDTH_W-1:0]);
        end
    end

    // ---------------------------------------------------------------- flow control
    // output register frees up when empty or taken, stage one follows it
    assign out_en     = !r_out_valid || !i_out_stall;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_in_stall = !s1_en;
    assign in_acc     = i_in_valid && s1_en;

    // ---------------------------------------------------------------- side recurrence
    msq_line_chain u_line (
        .i_clk  (i_clk),
        .i_ctrl (line_ctrl),
        .o_up   (up)
    );

    // a column at or past the clamped last column still closes the row
    assign row_end = (r_col >= r_last_col);

    always_comb begin
        // first row and first column just echo the cell
        if (r_first || r_col == '0) begin
            side = t_side'(i_cell_bit);
        end else if (!i_cell_bit) begin
            side = '0;
        end else begin
            side = min3(up, r_left, r_diag) + t_side'(1);
        end

        n_best = (side > r_best) ? side : r_best;

        if (row_end) begin
            n_col   = '0;
            n_left  = '0;
            n_diag  = '0;
            n_first = 1'b0;
        end else begin
            n_col   = r_col + t_col'(1);
            n_left  = side;
            n_diag  = up;
            n_first = r_first;
        end

        // end of matrix: scan restarts, row store is not cleared
        if (i_last_cell) begin
            n_col   = '0;
            n_left  = '0;
            n_diag  = '0;
            n_first = 1'b1;
        end

        line_ctrl.wr_en = in_acc;
        line_ctrl.load  = row_end || i_last_cell;
        line_ctrl.col   = r_col;
        line_ctrl.side  = side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_left  <= '0;
            r_diag  <= '0;
            r_first <= 1'b1;
            r_best  <= '0;
        end else if (in_acc) begin
            r_col   <= n_col;
            r_left  <= n_left;
            r_diag  <= n_diag;
            r_first <= n_first;
            r_best  <= i_last_cell ? '0 : n_best;
        end
    end

    // ---------------------------------------------------------------- stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_side <= side;
            r_s1_best <= n_best;
        end
    end

    // ---------------------------------------------------------------- output stage
    assign prod = r_s1_best * r_s1_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_side <= r_s1_side;
            r_out_area <= prod[AREA_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_side_here = r_out_side;
    assign o_best_area = r_out_area;

    // ---------------------------------------------------------------- checks
    `MSQ_ASSERT_RST(a_rst_empty, !i_rst_n |=> !r_s1_valid && !r_out_valid, "pipeline not empty after reset")
    `MSQ_ASSERT(a_last_clears, in_acc && i_last_cell |=> r_col == '0 && r_first && r_best == '0, "scan state not cleared after last cell")
    `MSQ_ASSERT(a_best_grows, in_acc && !i_last_cell |=> r_best >= $past(r_best), "best side shrank within a matrix")
    `MSQ_ASSERT(a_s1_hold, r_out_valid && i_out_stall && r_s1_valid |=> r_s1_valid && $stable(r_s1_side) && $stable(r_s1_best), "stage one lost data under stall")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for maximal_square_finder: directed table, then random matrices
module tb_top;
    import msq_pkg::*;

    localparam int GAP_MAX      = 18;
    localparam int RANDOM_CELLS = 700;
    localparam int N_DIRECTED   = 26;

    typedef struct {
        t_side side;
        t_area area;
    } t_square_result;

    // a row either writes row_width or sends one cell; typed rows carry their result
    typedef struct {
        bit          set_width;
        int unsigned width_word;
        bit          cell_v;
        bit          last_v;
        bit          typed;
        t_side       side;
        t_area       area;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_cell_bit  = 1'b0;
    logic                 i_last_cell = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_side                o_side_here;
    t_area                o_best_area;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    maximal_square_finder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cell_bit  (i_cell_bit),
        .i_last_cell (i_last_cell),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_side_here (o_side_here),
        .o_best_area (o_best_area),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // scan state of the square recurrence
    t_side  prev_row_side [MAX_COLS];
    t_side  left_run;
    t_side  diag_run;
    t_side  best_run;
    t_col   scan_col;
    bit     scan_first_row;
    t_width width_reg;

    t_square_result expected_squares [$];
    int             fail_count   = 0;
    int             cells_sent   = 0;
    bit             send_idle_on = 1'b0;
    bit             take_idle_on = 1'b0;
    int             take_hold    = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // reset width, first row: side is the cell, last cell clears the scan
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    0, 1, 1, 0, 1},
        // width 0 acts as one column
        '{1, 0,    0, 0, 0, 0, 0},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    0, 1, 1, 0, 1},
        // all-ones width clamps to 1024
        '{1, 2047, 0, 0, 0, 0, 0},
        '{0, 0,    1, 1, 1, 1, 1},
        // full 3x3 square of ones
        '{1, 3,    0, 0, 0, 0, 0},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    1, 0, 1, 1, 1},
        '{0, 0,    1, 0, 1, 2, 4},
        '{0, 0,    1, 0, 1, 2, 4},
        '{0, 0,    1, 0, 1, 1, 4},
        '{0, 0,    1, 0, 1, 2, 4},
        '{0, 0,    1, 1, 1, 3, 9},
        // width shrinks below the current column mid-row
        '{1, 4,    0, 0, 0, 0, 0},
        '{0, 0,    1, 0, 0, 0, 0},
        '{0, 0,    1, 0, 0, 0, 0},
        '{0, 0,    1, 0, 0, 0, 0},
        '{1, 2,    0, 0, 0, 0, 0},
        '{0, 0,    1, 0, 0, 0, 0},
        '{0, 0,    1, 0, 0, 0, 0},
        '{0, 0,    1, 1, 0, 0, 0}
    };

    function automatic int draw_gap(input bit on);
        return on ? int'($urandom_range(0, GAP_MAX)) : 0;
    endfunction

    function automatic void clear_scan();
        left_run       = '0;
        diag_run       = '0;
        scan_col       = '0;
        scan_first_row = 1'b1;
        best_run       = '0;
    endfunction

    // side of the largest square ending at this cell and the best area so far
    function automatic t_square_result predict_square(input bit cell_v, input bit last_v);
        int unsigned    w;
        int unsigned    col;
        int unsigned    up;
        int unsigned    side;
        t_square_result r;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_COLS) w = MAX_COLS;
        col = scan_col;
        up  = prev_row_side[col];
        if (scan_first_row || col == 0) begin
            side = cell_v;
        end else if (!cell_v) begin
            side = 0;
        end else begin
            side = (up < left_run) ? up : left_run;
            if (diag_run < side) side = diag_run;
            side = side + 1;
        end
        if (side > best_run) best_run = t_side'(side);
        r.side = t_side'(side);
        r.area = t_area'(32'(best_run) * 32'(best_run));
        prev_row_side[col] = t_side'(side);
        if (col + 1 >= w) begin
            scan_col       = '0;
            left_run       = '0;
            diag_run       = '0;
            scan_first_row = 1'b0;
        end else begin
            scan_col = t_col'(col + 1);
            left_run = t_side'(side);
            diag_run = t_side'(up);
        end
        if (last_v) clear_scan();
        return r;
    endfunction

    // hold the input side until every pending result has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_squares.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input bit wr, input logic [DATA_W-1:0] data,
                             output logic [DATA_W-1:0] rd);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {REG_ROW_WIDTH, 2'b00};
        pwdata  = wr ? data : '0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_row_width(input int unsigned value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] readback;
        word = DATA_W'(value) & DATA_W'(t_width'('1));
        // bits above the register are ignored
        if ($urandom_range(0, 1)) word = word | ($urandom() << WIDTH_W);
        drain_results();
        apb_cycle(1'b1, word, readback);
        width_reg = t_width'(word);
        apb_cycle(1'b0, '0, readback);
        if (readback !== DATA_W'(width_reg)) begin
            $error("row_width readback: expected %0d actual %0d", width_reg, readback);
            fail_count++;
        end
    endtask

    task automatic send_cell(input bit cell_v, input bit last_v, input bit typed,
                             input t_side side, input t_area area);
        int             gap;
        t_square_result want;
        gap = draw_gap(send_idle_on);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_cell_bit  = cell_v;
        i_last_cell = last_v;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_square(cell_v, last_v);
        if (typed) begin
            want.side = side;
            want.area = area;
        end
        expected_squares.push_back(want);
        cells_sent++;
    endtask

    // receiver stall, drawn once per result transfer
    always @(negedge i_clk) begin
        i_out_stall = (take_hold > 0);
        if (take_hold > 0) take_hold--;
    end

    always @(posedge i_clk) begin : result_check
        t_square_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_squares.size() == 0) begin
                $error("unexpected result: side_here %0d best_area %0d",
                       o_side_here, o_best_area);
                fail_count++;
            end else begin
                want = expected_squares.pop_front();
                if (o_side_here !== want.side) begin
                    $error("side_here: expected %0d actual %0d", want.side, o_side_here);
                    fail_count++;
                end
                if (o_best_area !== want.area) begin
                    $error("best_area: expected %0d actual %0d", want.area, o_best_area);
                    fail_count++;
                end
            end
            take_hold = draw_gap(take_idle_on);
        end
    end

    initial begin : stimulus
        int          n_cells;
        int          ew;
        int          rows;
        int          density;
        int          shrink_at;
        int          pick;
        int          start_count;
        int unsigned width_word;
        for (int c = 0; c < MAX_COLS; c++) prev_row_side[c] = '0;
        width_reg = WIDTH_RESET;
        clear_scan();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_on = $urandom_range(0, 1);
        take_idle_on = $urandom_range(0, 1);
        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_width) begin
                set_row_width(directed_rows[r].width_word);
            end else begin
                send_cell(directed_rows[r].cell_v, directed_rows[r].last_v,
                          directed_rows[r].typed, directed_rows[r].side,
                          directed_rows[r].area);
            end
        end

        start_count = cells_sent;
        while (cells_sent - start_count < RANDOM_CELLS) begin
            send_idle_on = ($urandom_range(0, 2) != 0);
            take_idle_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: random cells with stray last marks
                n_cells = $urandom_range(1, 30);
                for (int k = 0; k < n_cells; k++) begin
                    send_cell($urandom_range(0, 1),
                              k == n_cells - 1 || $urandom_range(0, 7) == 0, 1'b0, '0, '0);
                end
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0) width_word = 0;
                else if (pick == 1) width_word = $urandom_range(MAX_COLS + 1, 2047);
                else if (pick == 2) width_word = $urandom_range(17, 64);
                else width_word = $urandom_range(1, 16);
                set_row_width(width_word);
                ew = (width_word == 0) ? 1 : (width_word > MAX_COLS) ? MAX_COLS : width_word;
                if (ew > 64) begin
                    n_cells = $urandom_range(1, 40);
                end else begin
                    rows    = $urandom_range(1, (ew <= 16) ? ew + 2 : 3);
                    n_cells = rows * ew;
                    // matrix cut short mid-row
                    if ($urandom_range(0, 5) == 0) n_cells = $urandom_range(1, n_cells);
                end
                case ($urandom_range(0, 3))
                    0: begin
                        density = 50;
                    end
                    1: begin
                        density = 75;
                    end
                    2: begin
                        density = 92;
                    end
                    default: begin
                        density = 100;
                    end
                endcase
                shrink_at = -1;
                if (n_cells > 1 && ew > 1 && $urandom_range(0, 5) == 0)
                    shrink_at = $urandom_range(1, n_cells - 1);
                for (int k = 0; k < n_cells; k++) begin
                    // only narrowing mid-matrix, so the row above is always written
                    if (k == shrink_at) set_row_width($urandom_range(0, ew - 1));
                    send_cell($urandom_range(1, 100) <= density, k == n_cells - 1,
                              1'b0, '0, '0);
                end
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/msq_pkg.sv
sv/msq_cell.sv
sv/msq_line_chain.sv
sv/maximal_square_finder.sv
verif/tb_top.sv
